>>> rtl/core/lsr_pkg.sv
`default_nettype none
package lsr_pkg;

  typedef enum logic [2:0] {
    ST_DISC       = 3'd0,
    ST_CONNECTING = 3'd1,
    ST_CONNECTED  = 3'd2,
    ST_RECONN     = 3'd3,
    ST_TIMEDOUT   = 3'd4
  } link_state_t;

  localparam logic [3:0] CMD_TICK     = 4'd0;
  localparam logic [3:0] CMD_CONNECT  = 4'd1;
  localparam logic [3:0] CMD_DISCON   = 4'd2;
  localparam logic [3:0] CMD_SENT     = 4'd3;
  localparam logic [3:0] CMD_RCVD     = 4'd4;
  localparam logic [3:0] CMD_DROP     = 4'd5;
  localparam logic [3:0] CMD_BYTES_TX = 4'd6;
  localparam logic [3:0] CMD_RTT      = 4'd8;
  localparam logic [3:0] CMD_HBEAT    = 4'd9;
  localparam logic [3:0] CMD_CLEAR    = 4'd11;

  localparam logic [2:0] REG_CONN_TO  = 3'd0;
  localparam logic [2:0] REG_HB_INT   = 3'd1;
  localparam logic [2:0] REG_HB_MISS  = 3'd2;
  localparam logic [2:0] REG_RETRY_DL = 3'd3;
  localparam logic [2:0] REG_MAX_ATT  = 3'd4;
  localparam logic [2:0] REG_MAX_BPS  = 3'd5;
  localparam logic [2:0] REG_MAX_PKT  = 3'd6;

  localparam logic [31:0] WINDOW_MS = 32'd1000;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [15:0] elapsed_ms;
    logic [15:0] byte_count;
    logic [15:0] rtt_sample_ms;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  link_state;
    logic        state_changed;
    logic [2:0]  previous_state;
    logic        send_allowed;
    logic        size_ok;
    logic [2:0]  quality;
    logic [19:0] average_rtt_q4;
    logic [15:0] peak_rtt_ms;
    logic [7:0]  reconnect_total;
  } out_word_t;

  typedef struct packed {
    logic [15:0] connect_timeout_ms;
    logic [15:0] heartbeat_interval_ms;
    logic [7:0]  heartbeat_miss_limit;
    logic [15:0] reconnect_delay_ms;
    logic [7:0]  max_reconnect_attempts;
    logic [31:0] max_bytes_per_sec;
    logic [15:0] max_packet_size;
  } cfg_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT32 : s[31:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/lsr_cfg.sv
`default_nettype none
module lsr_cfg import lsr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output cfg_t             cfg
);
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{16'd5000, 16'd1000, 8'd3, 16'd2000, 8'd5, 32'd0, 16'd1400};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CONN_TO:  cfg.connect_timeout_ms     <= cfg_data[15:0];
        REG_HB_INT:   cfg.heartbeat_interval_ms  <= cfg_data[15:0];
        REG_HB_MISS:  cfg.heartbeat_miss_limit   <= cfg_data[7:0];
        REG_RETRY_DL: cfg.reconnect_delay_ms     <= cfg_data[15:0];
        REG_MAX_ATT:  cfg.max_reconnect_attempts <= cfg_data[7:0];
        REG_MAX_BPS:  cfg.max_bytes_per_sec      <= cfg_data;
        REG_MAX_PKT:  cfg.max_packet_size        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/lsr_core.sv
`default_nettype none
// Per-word state update; one word per cycle when en is high.
module lsr_core import lsr_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   en,
  input  in_word_t    in_w,
  input  cfg_t        cfg,
  output out_word_t   res
);
  link_state_t st, st_next;
  logic [31:0] conn_el, conn_el_next, hb_el, hb_el_next, retry_el, retry_el_next;
  logic [31:0] win_el, win_el_next, win_bytes, win_bytes_next;
  logic [7:0]  att, att_next;
  logic [19:0] avg, avg_next;
  logic [15:0] peak, peak_next;
  logic [31:0] sent, sent_next, rcvd, rcvd_next, drop, drop_next;

  logic [31:0] ms32, t_conn, t_hb, t_retry, t_win, hb_limit;
  logic [7:0]  att_inc;
  logic [23:0] avg_mix;
  logic [47:0] avg_div;
  logic        to_retry;
  logic [32:0] allow_sum;

  always_comb begin
    ms32     = {16'd0, in_w.elapsed_ms};
    t_win    = sat_add(win_el, ms32);
    t_conn   = sat_add(conn_el, ms32);
    t_hb     = sat_add(hb_el, ms32);
    t_retry  = sat_add(retry_el, ms32);
    hb_limit = 32'(cfg.heartbeat_interval_ms) * 32'(cfg.heartbeat_miss_limit);
    att_inc  = (att == 8'hFF) ? att : att + 8'd1;
    to_retry = (cfg.max_reconnect_attempts != 8'd0) && (att < cfg.max_reconnect_attempts);
    // (9*avg + 16*rtt)/10 via reciprocal multiply, exact for 24-bit numerators
    avg_mix  = 24'(avg) * 24'd9 + {4'd0, in_w.rtt_sample_ms, 4'd0};
    avg_div  = 48'(avg_mix) * 48'd13421773;
    st_next = st; conn_el_next = conn_el; hb_el_next = hb_el; retry_el_next = retry_el;
    win_el_next = win_el; win_bytes_next = win_bytes; att_next = att;
    avg_next = avg; peak_next = peak; sent_next = sent; rcvd_next = rcvd; drop_next = drop;
    unique case (in_w.cmd)
      CMD_TICK: begin
        win_el_next = t_win;
        if (t_win >= WINDOW_MS) begin
          win_el_next    = t_win - WINDOW_MS;
          win_bytes_next = '0;
        end
        unique case (st)
          ST_CONNECTING: begin
            conn_el_next = t_conn;
            if (cfg.connect_timeout_ms != 16'd0 && t_conn >= {16'd0, cfg.connect_timeout_ms}) begin
              if (to_retry) begin
                retry_el_next = '0; st_next = ST_RECONN;
              end else st_next = ST_TIMEDOUT;
            end
          end
          ST_CONNECTED: if (cfg.heartbeat_interval_ms != 16'd0) begin
            hb_el_next = t_hb;
            if (t_hb >= hb_limit) begin
              if (to_retry) begin
                retry_el_next = '0; st_next = ST_RECONN;
              end else st_next = ST_TIMEDOUT;
            end
          end
          ST_RECONN: begin
            retry_el_next = t_retry;
            if (t_retry >= {16'd0, cfg.reconnect_delay_ms}) begin
              att_next = att_inc;
              retry_el_next = '0;
              if (att_inc >= cfg.max_reconnect_attempts) st_next = ST_TIMEDOUT;
              else begin
                conn_el_next = '0; st_next = ST_CONNECTING;
              end
            end
          end
          default: ;
        endcase
      end
      CMD_CONNECT: begin
        conn_el_next = '0; att_next = '0; st_next = ST_CONNECTING;
      end
      CMD_DISCON:   st_next = ST_DISC;
      CMD_SENT:     sent_next = sat_add(sent, 32'd1);
      CMD_RCVD: begin
        rcvd_next = sat_add(rcvd, 32'd1);
        if (st == ST_CONNECTING) st_next = ST_CONNECTED;
      end
      CMD_DROP:     drop_next = sat_add(drop, 32'd1);
      CMD_BYTES_TX: win_bytes_next = sat_add(win_bytes, {16'd0, in_w.byte_count});
      CMD_RTT: begin
        if (in_w.rtt_sample_ms > peak) peak_next = in_w.rtt_sample_ms;
        avg_next = (avg == '0) ? {in_w.rtt_sample_ms, 4'd0} : avg_div[46:27];
      end
      CMD_HBEAT:    hb_el_next = '0;
      CMD_CLEAR: begin
        sent_next = '0; rcvd_next = '0; drop_next = '0; avg_next = '0; peak_next = '0;
      end
      default: ;
    endcase
    allow_sum = {1'b0, win_bytes_next} + 33'(in_w.byte_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_DISC; conn_el <= '0; hb_el <= '0; retry_el <= '0; att <= '0;
      win_el <= '0; win_bytes <= '0; avg <= '0; peak <= '0;
      sent <= '0; rcvd <= '0; drop <= '0;
    end else if (en) begin
      st <= st_next; conn_el <= conn_el_next; hb_el <= hb_el_next;
      retry_el <= retry_el_next; att <= att_next; win_el <= win_el_next;
      win_bytes <= win_bytes_next; avg <= avg_next; peak <= peak_next;
      sent <= sent_next; rcvd <= rcvd_next; drop <= drop_next;
    end
  end

  // Quality grading reads the updated counters and RTT average; kept here, products on 40 bits.
  logic [32:0] total;
  logic [39:0] drop100;
  logic [3:0]  pass;
  localparam logic [19:0] RTT_LIM [4] = '{20'd480, 20'd1280, 20'd2400, 20'd4800};
  localparam logic [3:0]  LOSS_LIM [4] = '{4'd1, 4'd3, 4'd8, 4'd15};
  always_comb begin
    total   = {1'b0, sent_next} + {1'b0, rcvd_next};
    drop100 = 40'(drop_next) * 40'd100;
    for (int i = 0; i < 4; i++) begin
      pass[i] = (avg_next < RTT_LIM[i]) &&
                ((total == '0) || (drop100 < 40'(total) * 40'(LOSS_LIM[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.link_state     <= st_next;
      res.state_changed  <= st_next != st;
      res.previous_state <= st;
      res.send_allowed   <= (cfg.max_bytes_per_sec == '0) ||
                            (allow_sum <= {1'b0, cfg.max_bytes_per_sec});
      res.size_ok        <= in_w.byte_count <= cfg.max_packet_size;
      res.quality        <= pass[0] ? 3'd0 : pass[1] ? 3'd1 : pass[2] ? 3'd2 :
                            pass[3] ? 3'd3 : 3'd4;
      res.average_rtt_q4 <= avg_next;
      res.peak_rtt_ms    <= peak_next;
      res.reconnect_total <= att_next;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/link_supervisor_with_reconnect_top.sv
`default_nettype none
// Latency: a word accepted at one edge has its result word valid after that edge.
// Throughput: one word per cycle while the receiver takes results; the result register refills as it drains.
// Reset (synchronous, rst high): link disconnected, timers, counters and RTT
// statistics zero, configuration registers at their defaults, no result held.
module link_supervisor_with_reconnect_top import lsr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  cfg_t cfg;
  logic take;

  // Ready whenever the result slot is empty or being drained this cycle.
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  lsr_cfg u_cfg (.clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg);
  lsr_core u_core (.clk, .rst, .en(take), .in_w(in_data), .cfg, .res(out_data));

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_ready) out_valid <= in_valid;
  end
endmodule
`default_nettype wire

>>> test/tb_link_supervisor_with_reconnect_top.sv
`default_nettype none
module tb_link_supervisor_with_reconnect_top;
  import lsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [3:0] CMD_BYTES_RX = 4'd7;   // no effect on link state or counters
  localparam logic [3:0] CMD_QUERY    = 4'd10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  link_supervisor_with_reconnect_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow of the link supervisor: configuration and state
  cfg_t        shadow_cfg;
  link_state_t link_now;
  logic [31:0] conn_ms, hb_ms, retry_ms, win_ms, win_bytes;
  logic [31:0] n_sent, n_rcvd, n_drop;
  logic [7:0]  attempts;
  logic [19:0] rtt_avg;
  logic [15:0] rtt_max;

  in_word_t  word_queue[$];    // words waiting for the driver
  out_word_t result_queue[$];  // predicted result words, oldest first
  int        mismatches = 0;
  int        cycles = 0;
  int        n_issued = 0;     // words handed to the driver
  int        n_checked = 0;    // result words seen by the monitor

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic shadow_reset();
    shadow_cfg = '{16'd5000, 16'd1000, 8'd3, 16'd2000, 8'd5, 32'd0, 16'd1400};
    link_now = ST_DISC;
    conn_ms = 0; hb_ms = 0; retry_ms = 0; win_ms = 0; win_bytes = 0;
    n_sent = 0; n_rcvd = 0; n_drop = 0; attempts = 0; rtt_avg = 0; rtt_max = 0;
  endtask

  function automatic void link_lost();
    if (shadow_cfg.max_reconnect_attempts != 0 &&
        attempts < shadow_cfg.max_reconnect_attempts) begin
      retry_ms = 0;
      link_now = ST_RECONN;
    end else begin
      link_now = ST_TIMEDOUT;
    end
  endfunction

  function automatic void apply_tick(logic [15:0] ms);
    logic [31:0] hb_limit;
    win_ms = add_sat(win_ms, {16'd0, ms});
    if (win_ms >= WINDOW_MS) begin
      win_ms = win_ms - WINDOW_MS;
      win_bytes = 0;
    end
    case (link_now)
      ST_CONNECTING: begin
        conn_ms = add_sat(conn_ms, {16'd0, ms});
        if (shadow_cfg.connect_timeout_ms != 0 &&
            conn_ms >= {16'd0, shadow_cfg.connect_timeout_ms})
          link_lost();
      end
      ST_CONNECTED: begin
        if (shadow_cfg.heartbeat_interval_ms != 0) begin
          hb_limit = shadow_cfg.heartbeat_interval_ms * shadow_cfg.heartbeat_miss_limit;
          hb_ms = add_sat(hb_ms, {16'd0, ms});
          if (hb_ms >= hb_limit) link_lost();
        end
      end
      ST_RECONN: begin
        retry_ms = add_sat(retry_ms, {16'd0, ms});
        if (retry_ms >= {16'd0, shadow_cfg.reconnect_delay_ms}) begin
          if (attempts != 8'd255) attempts++;
          retry_ms = 0;
          if (attempts >= shadow_cfg.max_reconnect_attempts) begin
            link_now = ST_TIMEDOUT;
          end else begin
            conn_ms = 0;
            link_now = ST_CONNECTING;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [2:0] grade_link();
    logic [32:0] total;
    logic [38:0] drop100;
    logic [31:0] rtt_lim[4];
    logic [3:0]  loss_lim[4];
    rtt_lim = '{480, 1280, 2400, 4800};
    loss_lim = '{1, 3, 8, 15};
    total = {1'b0, n_sent} + {1'b0, n_rcvd};
    drop100 = n_drop * 39'd100;
    for (int i = 0; i < 4; i++)
      if ({12'd0, rtt_avg} < rtt_lim[i] &&
          (total == 0 || drop100 < loss_lim[i] * {6'd0, total}))
        return i[2:0];
    return 3'd4;
  endfunction

  // Applies one word to the shadow and returns the result it should produce.
  function automatic out_word_t predict_link(in_word_t w);
    out_word_t   r;
    link_state_t was;
    logic [35:0] mix;
    was = link_now;
    case (w.cmd)
      CMD_TICK: apply_tick(w.elapsed_ms);
      CMD_CONNECT: begin
        conn_ms = 0; attempts = 0; link_now = ST_CONNECTING;
      end
      CMD_DISCON: link_now = ST_DISC;
      CMD_SENT: n_sent = add_sat(n_sent, 1);
      CMD_RCVD: begin
        n_rcvd = add_sat(n_rcvd, 1);
        if (link_now == ST_CONNECTING) link_now = ST_CONNECTED;
      end
      CMD_DROP: n_drop = add_sat(n_drop, 1);
      CMD_BYTES_TX: win_bytes = add_sat(win_bytes, {16'd0, w.byte_count});
      CMD_RTT: begin
        if (w.rtt_sample_ms > rtt_max) rtt_max = w.rtt_sample_ms;
        if (rtt_avg == 0) begin
          rtt_avg = {w.rtt_sample_ms, 4'd0};
        end else begin
          mix = (36'd9 * rtt_avg + {w.rtt_sample_ms, 4'd0}) / 10;
          rtt_avg = mix[19:0];
        end
      end
      CMD_HBEAT: hb_ms = 0;
      CMD_CLEAR: begin
        n_sent = 0; n_rcvd = 0; n_drop = 0; rtt_avg = 0; rtt_max = 0;
      end
      default: ;
    endcase
    r.link_state      = link_now;
    r.state_changed   = (link_now != was);
    r.previous_state  = was;
    r.send_allowed    = (shadow_cfg.max_bytes_per_sec == 0) ||
                        ({1'b0, win_bytes} + w.byte_count <= {1'b0, shadow_cfg.max_bytes_per_sec});
    r.size_ok         = (w.byte_count <= shadow_cfg.max_packet_size);
    r.quality         = grade_link();
    r.average_rtt_q4  = rtt_avg;
    r.peak_rtt_ms     = rtt_max;
    r.reconnect_total = attempts;
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Input handshake as seen at the rising edge; the driver acts on it at the
  // following falling edge.
  logic in_fire = 1'b0;
  always @(posedge clk) in_fire <= in_valid && in_ready && !rst;

  // Driver: launches queued words at the falling edge, predicting on acceptance.
  int gap_in = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_fire) begin
        result_queue.push_back(predict_link(in_data));
        gap_in = gap_len();
      end
      if (!in_valid || in_fire) begin
        if (gap_in == 0 && word_queue.size() != 0) begin
          in_data <= word_queue.pop_front();
          in_valid <= 1'b1;
          n_issued++;
        end else begin
          in_valid <= 1'b0;
          if (gap_in != 0) gap_in--;
        end
      end
    end
  end

  // Monitor: compare every result word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_checked++;
      if (result_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", out_data);
      end else begin
        out_word_t e;
        e = result_queue.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", e, out_data);
        end
      end
    end
  end

  // Receiver stalls; a result word is never due before the falling edge at
  // which its prediction is pushed.
  int gap_out = 0;
  always @(negedge clk) begin
    if (gap_out == 0) begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) gap_out = gap_len();
    end else begin
      out_ready <= 1'b0;
      gap_out--;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_word_t mk(logic [3:0] c, logic [15:0] ms = 0,
                                  logic [15:0] b = 0, logic [15:0] rt = 0);
    in_word_t w;
    w.cmd = c; w.elapsed_ms = ms; w.byte_count = b; w.rtt_sample_ms = rt;
    return w;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int p;
    w.cmd = 4'($urandom_range(0, 15));
    p = $urandom_range(0, 9);
    w.elapsed_ms = (p < 7) ? 16'($urandom_range(0, 1500)) : 16'($urandom());
    w.byte_count = (p < 6) ? 16'($urandom_range(0, 2000)) : 16'($urandom());
    w.rtt_sample_ms = (p < 7) ? 16'($urandom_range(0, 400)) : 16'($urandom());
    if ($urandom_range(0, 2) == 0) w.cmd = CMD_TICK;
    return w;
  endfunction

  // A plausible link session: connect, traffic, heartbeats, then loss.
  task automatic queue_session();
    word_queue.push_back(mk(CMD_CONNECT));
    if ($urandom_range(0, 3) != 0) word_queue.push_back(mk(CMD_RCVD));
    repeat ($urandom_range(3, 20)) begin
      case ($urandom_range(0, 6))
        0: word_queue.push_back(mk(CMD_HBEAT));
        1: word_queue.push_back(mk(CMD_RTT, 0, 0, 16'($urandom_range(1, 350))));
        2: word_queue.push_back(mk(CMD_BYTES_TX, 0, 16'($urandom_range(0, 1500))));
        3: word_queue.push_back(mk(CMD_TICK, 16'($urandom_range(0, 2500))));
        4: word_queue.push_back(mk(4'($urandom_range(CMD_SENT, CMD_DROP))));
        default: word_queue.push_back(rand_word());
      endcase
    end
    repeat ($urandom_range(0, 12))
      word_queue.push_back(mk(CMD_TICK, 16'($urandom_range(200, 3000))));
    if ($urandom_range(0, 2) == 0) word_queue.push_back(mk(CMD_DISCON));
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CONN_TO:  shadow_cfg.connect_timeout_ms = val[15:0];
      REG_HB_INT:   shadow_cfg.heartbeat_interval_ms = val[15:0];
      REG_HB_MISS:  shadow_cfg.heartbeat_miss_limit = val[7:0];
      REG_RETRY_DL: shadow_cfg.reconnect_delay_ms = val[15:0];
      REG_MAX_ATT:  shadow_cfg.max_reconnect_attempts = val[7:0];
      REG_MAX_BPS:  shadow_cfg.max_bytes_per_sec = val;
      REG_MAX_PKT:  shadow_cfg.max_packet_size = val[15:0];
      default: ;
    endcase
  endtask

  // Idle means nothing queued and every launched word has its result checked.
  task automatic drain();
    while (word_queue.size() != 0 || n_checked != n_issued)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_all(logic [31:0] v[7]);
    for (int i = 0; i < 7; i++) write_reg(i[2:0], v[i]);
  endtask

  initial begin
    logic [31:0] set[7];
    shadow_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every command, field extremes, saturation-free edge cases
    word_queue.push_back(mk(CMD_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    word_queue.push_back(mk(4'd15));
    word_queue.push_back(mk(CMD_DISCON));
    word_queue.push_back(mk(CMD_RTT, 0, 0, 16'hFFFF));
    word_queue.push_back(mk(CMD_RTT, 0, 0, 0));
    word_queue.push_back(mk(CMD_CLEAR));
    word_queue.push_back(mk(CMD_CONNECT));
    word_queue.push_back(mk(CMD_CONNECT));
    word_queue.push_back(mk(CMD_RCVD));
    word_queue.push_back(mk(CMD_SENT));
    word_queue.push_back(mk(CMD_DROP));
    word_queue.push_back(mk(CMD_BYTES_TX, 0, 16'hFFFF));
    word_queue.push_back(mk(CMD_BYTES_RX, 0, 1400));
    word_queue.push_back(mk(CMD_HBEAT));
    word_queue.push_back(mk(CMD_TICK, 999));
    word_queue.push_back(mk(CMD_TICK, 16'hFFFF));
    word_queue.push_back(mk(CMD_TICK, 2000));
    word_queue.push_back(mk(CMD_TICK, 2000));
    word_queue.push_back(mk(CMD_TICK, 0, 1401));
    drain();

    // Tight settings: every register, zero miss limit, zero attempts, small cap
    set = '{32'd0, 32'd100, 32'd0, 32'd0, 32'd0, 32'd1500, 32'd0};
    write_all(set);
    for (int i = 0; i < 60; i++)
      if ($urandom_range(0, 3) == 0) queue_session(); else word_queue.push_back(rand_word());
    drain();   // sender holds off until every result is in

    set = '{32'hFFFF, 32'hFFFF, 32'hFF, 32'hFFFF, 32'hFF, 32'hFFFF_FFFF, 32'hFFFF};
    write_all(set);
    repeat (10) queue_session();
    drain();

    set = '{32'd700, 32'd300, 32'd2, 32'd400, 32'd3, 32'd3000, 32'd1000};
    write_all(set);
    repeat (12) queue_session();
    repeat (30) word_queue.push_back(rand_word());
    drain();

    repeat (20) @(negedge clk);
    if (mismatches == 0 && result_queue.size() == 0 && word_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
